FILE: design/sprc_pkg.sv
// Shared types and constants for the span read coalescer.
// Used by the controller, the datapath and the top level; no dependencies.
package sprc_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SET     = 2'd2,
    OP_GATHER  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_GRANT  = 3'd0,
    KIND_NOFREE = 3'd1,
    KIND_REQ    = 3'd2,
    KIND_PLACE  = 3'd3,
    KIND_DONE   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_MERGE,
    ST_FLUSH,
    ST_REQ_RD,
    ST_REQ_OUT,
    ST_SPAN_RD,
    ST_SPAN_OUT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic exec_simple;
    logic gather_init;
    logic scan_step;
    logic merge;
    logic flush;
    logic out_clear;
    logic emit_req;
    logic emit_span;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic best_found;
    logic groups_zero;
    logic req_end;
    logic span_end;
  } status_t;

  localparam int unsigned KindW   = 3;
  localparam int unsigned SlotOutW = 4;
  localparam int unsigned AddrW   = 64;
  localparam int unsigned LenOutW = 29;
  localparam int unsigned OffOutW = 28;

endpackage

FILE: design/sprc_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module sprc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/sprc_ctrl.sv
// Controller state machine of the span read coalescer.
// Depends on sprc_pkg; drives the datapath through cmd_t and reads status_t.
module sprc_ctrl
  import sprc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic [1:0] opcode_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (op_e'(opcode_i) == OP_GATHER) begin
            cmd_o.gather_init = 1'b1;
            state_d = ST_SCAN;
          end else begin
            cmd_o.exec_simple = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_end) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        state_d = status_i.best_found ? ST_MERGE : ST_FLUSH;
      end
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d = ST_SCAN;
      end
      ST_FLUSH: begin
        cmd_o.flush     = 1'b1;
        cmd_o.out_clear = 1'b1;
        state_d = status_i.groups_zero ? ST_DONE : ST_REQ_RD;
      end
      ST_REQ_RD: begin
        state_d = ST_REQ_OUT;
      end
      ST_REQ_OUT: begin
        cmd_o.emit_req = 1'b1;
        if (status_i.req_end) begin
          cmd_o.out_clear = 1'b1;
          state_d = ST_SPAN_RD;
        end else begin
          state_d = ST_REQ_RD;
        end
      end
      ST_SPAN_RD: begin
        state_d = ST_SPAN_OUT;
      end
      ST_SPAN_OUT: begin
        cmd_o.emit_span = 1'b1;
        state_d = status_i.span_end ? ST_DONE : ST_SPAN_RD;
      end
      ST_DONE: begin
        cmd_o.emit_done = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: design/sprc_dp.sv
// Datapath of the span read coalescer: slot table, sort scan, merge and results.
// Depends on sprc_pkg and sprc_ram; commanded by sprc_ctrl.
module sprc_dp
  import sprc_pkg::*;
#(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic [1:0]           opcode_i,
  input  logic [3:0]           slot_i,
  input  logic [AddrW-1:0]     address_i,
  input  logic [23:0]          size_i,
  output logic                 strobe_o,
  output logic [KindW-1:0]     kind_o,
  output logic [SlotOutW-1:0]  slot_index_o,
  output logic [AddrW-1:0]     read_address_o,
  output logic [LenOutW-1:0]   length_o,
  output logic [OffOutW-1:0]   buffer_offset_o,
  output logic [3:0]           group_o,
  output logic                 last_o
);

  localparam int unsigned SW   = $clog2(SLOTS);
  localparam int unsigned CW   = SW + 1;
  localparam int unsigned EW   = SIZE_BITS + SW;
  localparam int unsigned GRPW = AddrW + 2 * EW + SW;
  localparam int unsigned SPW  = 2 * SW + EW;

  // Slot table.
  logic [SLOTS-1:0]     in_use_q;
  logic                 addr_we, len_we;
  logic [SW-1:0]        tbl_waddr;
  logic [AddrW-1:0]     addr_wdata, addr_rdata;
  logic [SIZE_BITS-1:0] len_wdata, len_rdata;
  logic                 free_found, slot_ok;
  logic [SW-1:0]        free_idx, slot_idx;
  op_e                  op;

  // Sort scan and merge state.
  logic [CW-1:0]        scan_cnt_q, pos_q, ngroups_q, out_cnt_q;
  logic                 best_found_q, first_q;
  logic [AddrW-1:0]     best_addr_q, last_addr_q;
  logic [SW-1:0]        best_slot_q, last_slot_q;
  logic [SIZE_BITS-1:0] best_len_q;
  logic [AddrW-1:0]     gstart_q;
  logic [EW-1:0]        gext_q, goff_q;
  logic [SW-1:0]        glead_q;
  logic [SW-1:0]        e_idx;
  logic                 cand;
  logic [AddrW-1:0]     span_dist;
  logic                 join_grp;
  logic [EW-1:0]        dist_w, reach, new_off;

  // Result memories.
  logic                 grp_we;
  logic [SW-1:0]        grp_waddr;
  logic [GRPW-1:0]      grp_wdata, grp_rdata;
  logic                 sp_we;
  logic [SPW-1:0]       sp_wdata, sp_rdata;
  logic [SW-1:0]        out_idx;

  logic                 strobe_q;

  assign op       = op_e'(opcode_i);
  assign slot_idx = SW'(slot_i);
  assign slot_ok  = (32'(slot_i) < SLOTS);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!in_use_q[k]) begin
        free_found = 1'b1;
        free_idx   = SW'(k);
      end
    end
  end

  always_comb begin
    addr_we    = 1'b0;
    len_we     = 1'b0;
    tbl_waddr  = slot_idx;
    addr_wdata = address_i;
    len_wdata  = SIZE_BITS'(size_i);
    if (cmd_i.exec_simple) begin
      unique case (op)
        OP_ALLOC: begin
          tbl_waddr  = free_idx;
          addr_wdata = '0;
          len_wdata  = '0;
          addr_we    = free_found;
          len_we     = free_found;
        end
        OP_RELEASE: begin
          len_wdata = '0;
          len_we    = slot_ok;
        end
        OP_SET: begin
          addr_we = slot_ok;
          len_we  = slot_ok;
        end
        default: ;
      endcase
    end
  end

  sprc_ram #(.WIDTH(AddrW), .DEPTH(SLOTS)) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (addr_we),
    .waddr_i (tbl_waddr),
    .wdata_i (addr_wdata),
    .raddr_i (scan_cnt_q[SW-1:0]),
    .rdata_o (addr_rdata)
  );

  sprc_ram #(.WIDTH(SIZE_BITS), .DEPTH(SLOTS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (tbl_waddr),
    .wdata_i (len_wdata),
    .raddr_i (scan_cnt_q[SW-1:0]),
    .rdata_o (len_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else if (cmd_i.exec_simple) begin
      if (op == OP_ALLOC && free_found) begin
        in_use_q[free_idx] <= 1'b1;
      end else if (op == OP_RELEASE && slot_ok) begin
        in_use_q[slot_idx] <= 1'b0;
      end
    end
  end

  // The read data belongs to the slot addressed in the previous cycle. A slot
  // in use with a nonzero length qualifies if its key (address, then index)
  // lies above the last one taken and below the best found so far in this pass.
  assign e_idx = SW'(scan_cnt_q - CW'(1));

  always_comb begin
    cand = 1'b0;
    if (scan_cnt_q != '0 && in_use_q[e_idx] && len_rdata != '0) begin
      cand = (first_q || addr_rdata > last_addr_q ||
              (addr_rdata == last_addr_q && e_idx > last_slot_q)) &&
             (!best_found_q || addr_rdata < best_addr_q);
    end
  end

  // A span joins the open request when it starts within or right at its end.
  assign span_dist = best_addr_q - gstart_q;
  assign join_grp  = (ngroups_q != '0) && (span_dist <= AddrW'(gext_q));
  assign dist_w    = EW'(span_dist);
  assign reach     = dist_w + EW'(best_len_q);
  assign new_off   = (ngroups_q == '0) ? '0 : goff_q + gext_q;

  assign grp_waddr = SW'(ngroups_q - CW'(1));
  assign grp_we    = (cmd_i.merge && !join_grp && ngroups_q != '0) ||
                     (cmd_i.flush && ngroups_q != '0);
  assign grp_wdata = {gstart_q, gext_q, goff_q, glead_q};

  assign sp_we    = cmd_i.merge;
  assign sp_wdata = join_grp ?
                    {best_slot_q, goff_q + dist_w, SW'(ngroups_q - CW'(1))} :
                    {best_slot_q, new_off, SW'(ngroups_q)};

  assign out_idx = out_cnt_q[SW-1:0];

  sprc_ram #(.WIDTH(GRPW), .DEPTH(SLOTS)) u_grp_ram (
    .clk_i   (clk_i),
    .we_i    (grp_we),
    .waddr_i (grp_waddr),
    .wdata_i (grp_wdata),
    .raddr_i (out_idx),
    .rdata_o (grp_rdata)
  );

  sprc_ram #(.WIDTH(SPW), .DEPTH(SLOTS)) u_span_ram (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (pos_q[SW-1:0]),
    .wdata_i (sp_wdata),
    .raddr_i (out_idx),
    .rdata_o (sp_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q   <= '0;
      pos_q        <= '0;
      ngroups_q    <= '0;
      out_cnt_q    <= '0;
      best_found_q <= 1'b0;
      first_q      <= 1'b1;
    end else begin
      if (cmd_i.gather_init) begin
        scan_cnt_q   <= '0;
        pos_q        <= '0;
        ngroups_q    <= '0;
        best_found_q <= 1'b0;
        first_q      <= 1'b1;
      end
      if (cmd_i.scan_step) begin
        scan_cnt_q <= scan_cnt_q + CW'(1);
        if (cand) begin
          best_found_q <= 1'b1;
        end
      end
      if (cmd_i.merge) begin
        scan_cnt_q   <= '0;
        best_found_q <= 1'b0;
        first_q      <= 1'b0;
        pos_q        <= pos_q + CW'(1);
        if (!join_grp) begin
          ngroups_q <= ngroups_q + CW'(1);
        end
      end
      if (cmd_i.out_clear) begin
        out_cnt_q <= '0;
      end else if (cmd_i.emit_req || cmd_i.emit_span) begin
        out_cnt_q <= out_cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gather_init) begin
      gstart_q <= '0;
      gext_q   <= '0;
      goff_q   <= '0;
      glead_q  <= '0;
    end
    if (cmd_i.scan_step && cand) begin
      best_addr_q <= addr_rdata;
      best_slot_q <= e_idx;
      best_len_q  <= len_rdata;
    end
    if (cmd_i.merge) begin
      last_addr_q <= best_addr_q;
      last_slot_q <= best_slot_q;
      if (join_grp) begin
        if (reach > gext_q) begin
          gext_q <= reach;
        end
      end else begin
        gstart_q <= best_addr_q;
        gext_q   <= EW'(best_len_q);
        goff_q   <= new_off;
        glead_q  <= best_slot_q;
      end
    end
  end

  assign status_o.scan_end    = (scan_cnt_q == CW'(SLOTS));
  assign status_o.best_found  = best_found_q;
  assign status_o.groups_zero = (ngroups_q == '0);
  assign status_o.req_end     = (out_cnt_q == ngroups_q - CW'(1));
  assign status_o.span_end    = (out_cnt_q == pos_q - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (cmd_i.exec_simple && op == OP_ALLOC) || cmd_i.emit_req ||
                  cmd_i.emit_span || cmd_i.emit_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_simple && op == OP_ALLOC) begin
      kind_o          <= free_found ? KIND_GRANT : KIND_NOFREE;
      slot_index_o    <= free_found ? SlotOutW'(free_idx) : '0;
      read_address_o  <= '0;
      length_o        <= '0;
      buffer_offset_o <= '0;
      group_o         <= '0;
      last_o          <= 1'b1;
    end else if (cmd_i.emit_req) begin
      kind_o          <= KIND_REQ;
      slot_index_o    <= SlotOutW'(grp_rdata[SW-1:0]);
      read_address_o  <= grp_rdata[GRPW-1 -: AddrW];
      length_o        <= LenOutW'(grp_rdata[SW+2*EW-1 -: EW]);
      buffer_offset_o <= OffOutW'(grp_rdata[SW+EW-1 -: EW]);
      group_o         <= 4'(out_cnt_q);
      last_o          <= 1'b0;
    end else if (cmd_i.emit_span) begin
      kind_o          <= KIND_PLACE;
      slot_index_o    <= SlotOutW'(sp_rdata[SPW-1 -: SW]);
      read_address_o  <= '0;
      length_o        <= '0;
      buffer_offset_o <= OffOutW'(sp_rdata[SW+EW-1 -: EW]);
      group_o         <= 4'(sp_rdata[SW-1:0]);
      last_o          <= 1'b0;
    end else if (cmd_i.emit_done) begin
      kind_o          <= KIND_DONE;
      slot_index_o    <= '0;
      read_address_o  <= '0;
      length_o        <= LenOutW'(goff_q + gext_q);
      buffer_offset_o <= '0;
      group_o         <= '0;
      last_o          <= 1'b1;
    end
  end

  assign strobe_o = strobe_q;

endmodule

FILE: design/span_read_coalescer_core.sv
// Top level of the span read coalescer: controller plus datapath.
// Depends on sprc_pkg, sprc_ctrl, sprc_dp and sprc_ram.
//
// Allocate answers in the cycle after it is taken; release and set give no
// result. Gather finds the spans in address order by scanning every slot
// once per span through the single read port of the slot table, then makes
// a final empty pass and the flush, and emits each request, each placement
// and then the done item. Results appear on a one-cycle strobe and cannot
// be held off; busy is low again by the cycle in which the final item of a
// gather is shown.
module span_read_coalescer_core
  import sprc_pkg::*;
#(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode_i,
  input  logic [3:0]           slot_i,
  input  logic [AddrW-1:0]     address_i,
  input  logic [23:0]          size_i,
  output logic                 strobe_o,
  output logic [KindW-1:0]     kind_o,
  output logic [SlotOutW-1:0]  slot_index_o,
  output logic [AddrW-1:0]     read_address_o,
  output logic [LenOutW-1:0]   length_o,
  output logic [OffOutW-1:0]   buffer_offset_o,
  output logic [3:0]           group_o,
  output logic                 last_o
);

  cmd_t    cmd;
  status_t status;

  sprc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  sprc_dp #(.SLOTS(SLOTS), .SIZE_BITS(SIZE_BITS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .opcode_i        (opcode_i),
    .slot_i          (slot_i),
    .address_i       (address_i),
    .size_i          (size_i),
    .strobe_o        (strobe_o),
    .kind_o          (kind_o),
    .slot_index_o    (slot_index_o),
    .read_address_o  (read_address_o),
    .length_o        (length_o),
    .buffer_offset_o (buffer_offset_o),
    .group_o         (group_o),
    .last_o          (last_o)
  );

endmodule
